[rtl/sis_pkg.sv]
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants for the sorted insert stack
// Item layouts, operation and status codes, and store sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

  // number of cells in the store
  localparam int unsigned DEPTH = 8;
  // index into the store and fill count widths
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // operation codes
  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } sis_func_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } sis_status_e;

  // input item
  typedef struct packed {
    sis_func_e          func;
    logic signed [31:0] item_value;
  } sis_in_t;

  // result item
  typedef struct packed {
    sis_status_e        status;
    logic signed [31:0] popped_value;
    logic        [3:0]  entry_count;
  } sis_out_t;

  // per-cell control from the top level
  typedef struct packed {
    logic load_en;   // accepted push into a store with room
    logic occupied;  // cell holds an entry
    logic tail;      // cell is the first free slot
  } sis_cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/sorted_insert_stack.sv]
// ----------------------------------------------------------------------------
// sorted_insert_stack: bounded stack kept in ascending order
// A row of cells inserts a pushed value at its sorted place, all cells at once;
// a pop removes and returns the top, largest entry.
// ----------------------------------------------------------------------------
// the result of an item is registered and is on the output in the cycle after it is taken
// throughput: one item per cycle while results are taken; the row of cells
//   compares and shifts in parallel, and the output register holds one result
// reset: fill count and output valid clear asynchronously; entries are not
//   cleared and are only read once written
`default_nettype none

module sorted_insert_stack
  import sis_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_stall_o,
  input  wire sis_in_t in_data_i,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  output sis_out_t     out_data_o
);

  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   count_d;
  logic               out_valid_q;
  sis_out_t           out_q;
  sis_out_t           res;
  logic               accept;
  logic               full;
  logic               empty;
  logic               load_en;
  logic signed [31:0] cell_val [DEPTH];
  logic [DEPTH-1:0]   cell_gt;

  // handshake: take an item unless a result is stuck in the output register
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign load_en    = accept && (in_data_i.func == FUNC_PUSH) && !full;

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sis_cell_ctrl_t     ctrl;
    logic signed [31:0] below_val;
    logic               below_gt;

    assign ctrl = '{load_en:  load_en,
                    occupied: (CNT_W'(i) < count_q),
                    tail:     (CNT_W'(i) == count_q)};

    if (i == 0) begin : g_bottom
      assign below_val = '0;
      assign below_gt  = 1'b0;
    end else begin : g_upper
      assign below_val = cell_val[i-1];
      assign below_gt  = cell_gt[i-1];
    end

    sis_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .push_value_i (in_data_i.item_value),
      .below_value_i(below_val),
      .below_gt_i   (below_gt),
      .value_o      (cell_val[i]),
      .gt_o         (cell_gt[i])
    );
  end

  // result and next fill count
  always_comb begin
    count_d          = count_q;
    res.status       = ST_DONE;
    res.popped_value = '0;
    unique case (in_data_i.func)
      FUNC_PUSH: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
      FUNC_POP: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          count_d          = count_q - 1'b1;
          res.popped_value = cell_val[IDX_W'(count_q - 1'b1)];
        end
      end
      default: begin
        res.status = ST_DONE;
      end
    endcase
    res.entry_count = 4'(count_d);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      out_valid_q <= accept || (out_valid_q && out_stall_i);
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.entry_count == 4'(count_q))
    else $error("reported count differs from fill count");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.func == FUNC_POP && empty |=> out_q.status == ST_EMPTY)
    else $error("pop of empty store not flagged");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_en |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not grow the store");
`endif

endmodule

`default_nettype wire

[rtl/sis_cell.sv]
// ----------------------------------------------------------------------------
// sis_cell: one slot of the sorted insert stack
// Compares the pushed value with its entry, tells the cell above, and on a
// push either takes the entry from below, takes the new value, or holds.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_cell
  import sis_pkg::*;
(
  input  wire                     clk_i,
  input  wire sis_cell_ctrl_t     ctrl_i,
  input  wire logic signed [31:0] push_value_i,
  input  wire logic signed [31:0] below_value_i,
  input  wire logic               below_gt_i,
  output logic signed [31:0]      value_o,
  output logic                    gt_o
);

  logic signed [31:0] value_q;
  logic signed [31:0] value_d;

  // entry is occupied and strictly greater than the pushed value
  assign gt_o = ctrl_i.occupied && (push_value_i < value_q);

  // shift up from below, insert here, or hold
  always_comb begin
    value_d = value_q;
    if (ctrl_i.load_en) begin
      priority if (below_gt_i) begin
        value_d = below_value_i;
      end else if (gt_o || ctrl_i.tail) begin
        value_d = push_value_i;
      end
    end
  end

  // entry storage, undefined until written
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire
